// ===== src/assert_macros.svh =====
// shared assertion macros for the compositor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked while out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
    else $error("implication check failed");

// expression must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== src/pac_pkg.sv =====
package pac_pkg;

  // stored pixel formats
  localparam logic [1:0] FMT_RGB565  = 2'd0;
  localparam logic [1:0] FMT_BGR565S = 2'd1;
  localparam logic [1:0] FMT_RGB332  = 2'd2;

  // operation kinds
  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_BLEND = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] source_pixel;
    logic [15:0] dest_pixel;
    logic [7:0]  global_alpha;
  } item_t;

  typedef struct packed {
    logic [15:0] new_pixel;
    logic [15:0] panel_pixel;
  } result_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // rounded divide by 255 of a product of two bytes
  function automatic logic [7:0] div255_round(input logic [15:0] v);
    logic [16:0] x;
    logic [17:0] s;
    x = {1'b0, v} + 17'd127;
    s = {1'b0, x} + {9'd0, x[16:8]} + 18'd1;
    return s[15:8];
  endfunction

  // stored word to 8-bit channels by bit replication
  function automatic rgb_t unpack_px(input logic [1:0] fmt, input logic [15:0] px);
    rgb_t        c;
    logic [15:0] bgr;
    bgr = {px[7:0], px[15:8]};
    case (fmt)
      FMT_RGB332: begin
        c.r = {px[7:5], px[7:5], px[7:6]};
        c.g = {px[4:2], px[4:2], px[4:3]};
        c.b = {px[1:0], px[1:0], px[1:0], px[1:0]};
      end
      FMT_BGR565S: begin
        c.r = {bgr[4:0], bgr[4:2]};
        c.g = {bgr[10:5], bgr[10:9]};
        c.b = {bgr[15:11], bgr[15:13]};
      end
      default: begin
        c.r = {px[15:11], px[15:13]};
        c.g = {px[10:5], px[10:9]};
        c.b = {px[4:0], px[4:2]};
      end
    endcase
    return c;
  endfunction

  // 8-bit channels to stored word
  function automatic logic [15:0] pack_px(input logic [1:0] fmt, input rgb_t c);
    logic [15:0] w;
    logic [15:0] bgr;
    bgr = {c.b[7:3], c.g[7:2], c.r[7:3]};
    case (fmt)
      FMT_RGB332:  w = {8'h00, c.r[7:5], c.g[7:5], c.b[7:6]};
      FMT_BGR565S: w = {bgr[7:0], bgr[15:8]};
      default:     w = {c.r[7:3], c.g[7:2], c.b[7:3]};
    endcase
    return w;
  endfunction

  // source plus scaled destination, clamped at full scale
  function automatic logic [7:0] add_sat(input logic [7:0] s, input logic [7:0] d);
    logic [8:0] v;
    v = {1'b0, s} + {1'b0, d};
    return v[8] ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== src/pac_scale.sv =====
module pac_scale (
  input  logic       clk_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  output logic [7:0] q_o
);
  import pac_pkg::*;

  logic [15:0] prod_q;
  logic [15:0] prod_d;

  // byte product, registered ahead of the rounding divide
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // rounded divide by 255 on the registered product
  assign q_o = div255_round(prod_q);

endmodule

// ===== src/pixel_alpha_compositor.sv =====
// channel   | signals                            | dir | handshake
// ----------+------------------------------------+-----+-------------------------------
// item      | start, busy, item_i                | in  | taken when start && !busy
// result    | result_valid_o, result_o           | out | one-cycle strobe, no backpressure
// config    | cfg_we_i, cfg_wdata_i              | in  | written when cfg_we_i is high
//
// four register stages: source multiply, source divide, destination multiply,
// divide/add/pack into the output register; one beat may enter every cycle.
// busy is always low: nothing downstream can stall the pipeline.
// asynchronous active-low reset clears the stage valid bits and the format register.
`include "assert_macros.svh"

module pixel_alpha_compositor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pac_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  output logic             result_valid_o,
  output pac_pkg::result_t result_o
);
  import pac_pkg::*;

  logic [1:0] pixel_format_q;

  // stage valid bits
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q;

  // side payload per stage
  logic [1:0] fmt_a_q, fmt_b_q, fmt_c_q;
  logic       keep_a_q, keep_b_q, keep_c_q;
  rgb_t       dst_a_q, dst_b_q, dst_c_q;
  rgb_t       src_b_q, src_c_q;
  logic [7:0] sa_b_q, sa_c_q;

  // stage a inputs
  logic [7:0] in_sa;
  rgb_t       in_src;
  logic [7:0] chan_m;
  logic [7:0] alpha_m;
  logic       in_keep;
  rgb_t       in_dst;

  // scaler outputs
  logic [7:0] sa_sc;
  rgb_t       src_sc;
  rgb_t       dst_sc;

  // output stage
  rgb_t       over_c;
  rgb_t       fin_c;
  logic [15:0] stored_d;
  result_t    result_d;
  result_t    result_q;

  assign busy = 1'b0;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_RGB565;
    end else if (cfg_we_i) begin
      pixel_format_q <= cfg_wdata_i;
    end
  end

  // input decode: destination unpack and scale factors
  assign in_sa    = item_i.source_pixel[31:24];
  assign in_src.r = item_i.source_pixel[23:16];
  assign in_src.g = item_i.source_pixel[15:8];
  assign in_src.b = item_i.source_pixel[7:0];
  assign in_dst   = unpack_px(pixel_format_q, item_i.dest_pixel);

  always_comb begin
    chan_m  = ALPHA_OPAQUE;
    alpha_m = ALPHA_OPAQUE;
    in_keep = 1'b0;
    case (item_i.kind)
      KIND_FILL:  chan_m = in_sa;
      KIND_COPY:  chan_m = ALPHA_OPAQUE;
      KIND_BLEND: begin
        chan_m  = item_i.global_alpha;
        alpha_m = item_i.global_alpha;
        in_keep = (item_i.global_alpha == 8'h00);
      end
      KIND_NOP:   in_keep = 1'b1;
      default:    in_keep = 1'b1;
    endcase
  end

  // source scaling: product at stage a, rounded quotient into stage b
  pac_scale u_scale_sa (.clk_i(clk_i), .a_i(in_sa),    .b_i(alpha_m), .q_o(sa_sc));
  pac_scale u_scale_sr (.clk_i(clk_i), .a_i(in_src.r), .b_i(chan_m),  .q_o(src_sc.r));
  pac_scale u_scale_sg (.clk_i(clk_i), .a_i(in_src.g), .b_i(chan_m),  .q_o(src_sc.g));
  pac_scale u_scale_sb (.clk_i(clk_i), .a_i(in_src.b), .b_i(chan_m),  .q_o(src_sc.b));

  // destination scaling by the inverse source alpha
  pac_scale u_scale_dr (.clk_i(clk_i), .a_i(dst_b_q.r), .b_i(~sa_b_q), .q_o(dst_sc.r));
  pac_scale u_scale_dg (.clk_i(clk_i), .a_i(dst_b_q.g), .b_i(~sa_b_q), .q_o(dst_sc.g));
  pac_scale u_scale_db (.clk_i(clk_i), .a_i(dst_b_q.b), .b_i(~sa_b_q), .q_o(dst_sc.b));

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= start && !busy;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  // payload alongside the scalers
  always_ff @(posedge clk_i) begin
    fmt_a_q  <= pixel_format_q;
    keep_a_q <= in_keep;
    dst_a_q  <= in_dst;

    fmt_b_q  <= fmt_a_q;
    keep_b_q <= keep_a_q;
    dst_b_q  <= dst_a_q;
    src_b_q  <= src_sc;
    sa_b_q   <= sa_sc;

    fmt_c_q  <= fmt_b_q;
    keep_c_q <= keep_b_q;
    dst_c_q  <= dst_b_q;
    src_c_q  <= src_b_q;
    sa_c_q   <= sa_b_q;
  end

  // source-over with saturation
  assign over_c.r = add_sat(src_c_q.r, dst_sc.r);
  assign over_c.g = add_sat(src_c_q.g, dst_sc.g);
  assign over_c.b = add_sat(src_c_q.b, dst_sc.b);

  // pick destination, source or composite, then repack
  always_comb begin
    if (keep_c_q || sa_c_q == 8'h00) begin
      fin_c = dst_c_q;
    end else if (sa_c_q == ALPHA_OPAQUE) begin
      fin_c = src_c_q;
    end else begin
      fin_c = over_c;
    end
    stored_d             = pack_px(fmt_c_q, fin_c);
    result_d.new_pixel   = stored_d;
    result_d.panel_pixel = (fmt_c_q == FMT_RGB332)
                         ? pack_px(FMT_RGB565, unpack_px(FMT_RGB332, stored_d))
                         : stored_d;
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = vld_d_q;
  assign result_o       = result_q;

  // every accepted beat gives exactly one result
  `ASSERT_IMPL(a_beat_out, clk_i, rst_ni, start && !busy, ##4 result_valid_o)
  `ASSERT_IMPL(a_out_beat, clk_i, rst_ni, result_valid_o, $past(start && !busy, 4))

  // transparent copy in RGB565 returns the destination word untouched
  `ASSERT_IMPL(a_clear_copy, clk_i, rst_ni,
    start && item_i.kind == KIND_COPY && item_i.source_pixel[31:24] == 8'h00 &&
    pixel_format_q == FMT_RGB565,
    ##4 (result_o.new_pixel == $past(item_i.dest_pixel, 4)))

  // panel word differs from the stored word only for the one-byte format
  `ASSERT_NEVER(a_panel_word, clk_i, rst_ni,
    result_valid_o && result_o.new_pixel[15:8] != 8'h00 &&
    result_o.panel_pixel != result_o.new_pixel)

endmodule

// ===== bench/pixel_alpha_compositor_tb.sv =====
`timescale 1ns / 100ps

module pixel_alpha_compositor_tb;
  import pac_pkg::*;

  // format code that the block treats as RGB565
  localparam logic [1:0] FMT_SPARE = 2'd3;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = FMT_RGB565;
  logic    result_valid_o;
  result_t result_o;

  int unsigned gap_pct = 0;

  pixel_alpha_compositor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected composited pixels, in order of accepted beats
  class composite_scoreboard;
    logic [1:0] format;
    result_t    pixels_due[$];
    int         mismatches;

    function new();
      format     = FMT_RGB565;
      mismatches = 0;
    endfunction

    // rounded divide by 255
    function int unsigned div255r(input int unsigned v);
      return (v + 127) / 255;
    endfunction

    // stored word to 8-bit channels, low bits filled by replication
    function rgb_t unpack_word(input logic [1:0] fmt, input logic [15:0] px);
      rgb_t        c;
      logic [15:0] w;
      logic [4:0]  r5;
      logic [5:0]  g6;
      logic [4:0]  b5;
      logic [2:0]  r3;
      logic [2:0]  g3;
      logic [1:0]  b2;
      if (fmt == FMT_RGB332) begin
        r3 = px[7:5];
        g3 = px[4:2];
        b2 = px[1:0];
        c.r = {r3, r3, r3[2:1]};
        c.g = {g3, g3, g3[2:1]};
        c.b = {4{b2}};
        return c;
      end
      if (fmt == FMT_BGR565S) begin
        w  = {px[7:0], px[15:8]};
        b5 = w[15:11];
        g6 = w[10:5];
        r5 = w[4:0];
      end else begin
        r5 = px[15:11];
        g6 = px[10:5];
        b5 = px[4:0];
      end
      c.r = {r5, r5[4:2]};
      c.g = {g6, g6[5:4]};
      c.b = {b5, b5[4:2]};
      return c;
    endfunction

    // 8-bit channels to stored word
    function logic [15:0] pack_word(input logic [1:0] fmt, input rgb_t c);
      logic [15:0] w;
      if (fmt == FMT_RGB332) return {8'h00, c.r[7:5], c.g[7:5], c.b[7:6]};
      if (fmt == FMT_BGR565S) begin
        w = {c.b[7:3], c.g[7:2], c.r[7:3]};
        return {w[7:0], w[15:8]};
      end
      return {c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

    // source channel over scaled destination, clamped at 255
    function logic [7:0] over_sat(input int unsigned s, input int unsigned d,
                                  input int unsigned inv);
      int unsigned v;
      v = s + div255r(d * inv);
      return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function result_t predict_pixel(input logic [1:0] fmt_reg, input item_t it);
      result_t     res;
      logic [1:0]  fmt;
      rgb_t        d;
      rgb_t        o;
      int unsigned sa, sr, sg, sb, ga;
      bit          keep;
      fmt  = (fmt_reg == FMT_SPARE) ? FMT_RGB565 : fmt_reg;
      d    = unpack_word(fmt, it.dest_pixel);
      sa   = it.source_pixel[31:24];
      sr   = it.source_pixel[23:16];
      sg   = it.source_pixel[15:8];
      sb   = it.source_pixel[7:0];
      ga   = it.global_alpha;
      keep = 1'b0;
      case (it.kind)
        KIND_FILL: begin
          sr = div255r(sr * sa);
          sg = div255r(sg * sa);
          sb = div255r(sb * sa);
        end
        KIND_BLEND: begin
          if (ga == 0) begin
            keep = 1'b1;
          end else begin
            sa = div255r(sa * ga);
            sr = div255r(sr * ga);
            sg = div255r(sg * ga);
            sb = div255r(sb * ga);
          end
        end
        KIND_NOP: keep = 1'b1;
        default: ;
      endcase
      o = d;
      if (!keep) begin
        if (it.kind == KIND_FILL && sa == ALPHA_OPAQUE) begin
          // opaque fill writes the straight colour as given
          o.r = it.source_pixel[23:16];
          o.g = it.source_pixel[15:8];
          o.b = it.source_pixel[7:0];
        end else if (sa == ALPHA_OPAQUE) begin
          o.r = 8'(sr);
          o.g = 8'(sg);
          o.b = 8'(sb);
        end else if (sa != 0) begin
          o.r = over_sat(sr, d.r, 255 - sa);
          o.g = over_sat(sg, d.g, 255 - sa);
          o.b = over_sat(sb, d.b, 255 - sa);
        end
      end
      res.new_pixel   = pack_word(fmt, o);
      res.panel_pixel = res.new_pixel;
      if (fmt == FMT_RGB332)
        res.panel_pixel = pack_word(FMT_RGB565, unpack_word(FMT_RGB332, res.new_pixel));
      return res;
    endfunction

    function void note_item(input item_t it);
      pixels_due.push_back(predict_pixel(format, it));
    endfunction

    function void flag(input string what, input logic [15:0] want, input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected, new %h panel %h",
                   $time, got.new_pixel, got.panel_pixel);
        return;
      end
      want = pixels_due.pop_front();
      if (got.new_pixel !== want.new_pixel) flag("new_pixel", want.new_pixel, got.new_pixel);
      if (got.panel_pixel !== want.panel_pixel)
        flag("panel_pixel", want.panel_pixel, got.panel_pixel);
    endfunction
  endclass

  composite_scoreboard books = new();

  // sample accepted beats and result strobes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) books.note_item(item_i);
      if (result_valid_o) books.check_result(result_o);
    end
  end

  function automatic item_t pixel_beat(input logic [1:0] kind, input logic [31:0] src,
                                       input logic [15:0] dst, input logic [7:0] ga);
    item_t it;
    it.kind         = kind;
    it.source_pixel = src;
    it.dest_pixel   = dst;
    it.global_alpha = ga;
    return it;
  endfunction

  // mostly premultiplied sources, alpha and global alpha often at the ends
  function automatic item_t random_beat();
    item_t      it;
    logic [7:0] a;
    logic [7:0] ga;
    logic [1:0] kind;
    case ($urandom_range(0, 15))
      0:       kind = KIND_NOP;
      1, 2, 3, 4, 5: kind = KIND_FILL;
      6, 7, 8, 9, 10: kind = KIND_COPY;
      default: kind = KIND_BLEND;
    endcase
    case ($urandom_range(0, 5))
      0:       a = 8'h00;
      1:       a = 8'hFF;
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       ga = 8'h00;
      1:       ga = 8'hFF;
      default: ga = 8'($urandom);
    endcase
    it = pixel_beat(kind, {a, 24'($urandom)}, 16'($urandom), ga);
    if (kind != KIND_FILL && $urandom_range(0, 3) != 0) begin
      it.source_pixel[23:16] = 8'($urandom_range(0, a));
      it.source_pixel[15:8]  = 8'($urandom_range(0, a));
      it.source_pixel[7:0]   = 8'($urandom_range(0, a));
    end
    return it;
  endfunction

  // present one beat, with an optional idle burst first
  task automatic send_pixel(input item_t it);
    bit taken;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (books.pixels_due.size() != 0);
  endtask

  // format changes only with the pipeline empty
  task automatic write_format(input logic [1:0] fmt);
    drain();
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= fmt;
    books.format = fmt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    automatic logic [1:0] phase_fmt[7] = '{FMT_RGB332, FMT_BGR565S, FMT_SPARE, FMT_RGB565,
                                           FMT_RGB332, FMT_BGR565S, FMT_RGB565};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset format
    send_pixel(pixel_beat(KIND_FILL,  32'hFFFF_FFFF, 16'h0000, 8'h00));
    send_pixel(pixel_beat(KIND_FILL,  32'h00FF_FFFF, 16'hFFFF, 8'hFF));
    send_pixel(pixel_beat(KIND_FILL,  32'h80FF_4010, 16'h1234, 8'h00));
    send_pixel(pixel_beat(KIND_COPY,  32'hFF12_3456, 16'hFFFF, 8'h00));
    send_pixel(pixel_beat(KIND_COPY,  32'h0000_0000, 16'hA5A5, 8'hFF));
    send_pixel(pixel_beat(KIND_COPY,  32'h7F40_2010, 16'h5A5A, 8'h00));
    send_pixel(pixel_beat(KIND_COPY,  32'h10FF_FFFF, 16'hFFFF, 8'h00));
    send_pixel(pixel_beat(KIND_BLEND, 32'hFFFF_FFFF, 16'h0000, 8'h00));
    send_pixel(pixel_beat(KIND_BLEND, 32'hFFAB_CDEF, 16'h0F0F, 8'hFF));
    send_pixel(pixel_beat(KIND_BLEND, 32'h8080_4020, 16'hF0F0, 8'h80));
    send_pixel(pixel_beat(KIND_BLEND, 32'h20FF_FFFF, 16'hFFFF, 8'hFF));
    send_pixel(pixel_beat(KIND_NOP,   32'hFFFF_FFFF, 16'hBEEF, 8'hFF));
    send_pixel(pixel_beat(KIND_FILL,  32'h0000_0000, 16'h0000, 8'h00));

    // random phases, one format each, no idling in the last one
    foreach (phase_fmt[p]) begin
      write_format(phase_fmt[p]);
      for (int n = 0; n < 85; n++) begin
        if (n % 20 == 0)
          gap_pct = (p == 6 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
        send_pixel(random_beat());
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (books.mismatches == 0 && books.pixels_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
